// ===== sv/pet_pkg.sv =====
package pet_pkg;

   localparam int PIX_BITS    = 8;
   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 13;
   localparam int THR_BITS    = 8;
   localparam int SUM_BITS    = 10;   // sum of three pixels
   localparam int DIFF_BITS   = 9;    // signed bottom minus top
   localparam int GRAD_BITS   = 11;   // signed gradient, |g| <= 765
   localparam int SQ_BITS     = 20;   // g*g <= 585225
   localparam int MIN_DIM     = 3;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [THR_BITS-1:0]    THR_RESET    = 8'd100;

   localparam logic [PIX_BITS-1:0] EDGE_ON  = 8'd255;
   localparam logic [PIX_BITS-1:0] EDGE_OFF = 8'd0;

   // register indexes on the csr port, byte address 4*index
   localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

   typedef logic [PIX_BITS-1:0] pixel_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  image_width;
      logic [HEIGHT_BITS-1:0] image_height;
      logic [THR_BITS-1:0]    edge_threshold;
   } cfg_type;

endpackage

// ===== sv/prewitt_edge_threshold.sv =====
// Streaming 3x3 Prewitt edge detector with threshold.
// req_*: 8-bit grayscale pixels in raster order; req_tuser[0] marks the
//   first pixel of a frame and puts the position back to row 0, column 0.
// rsp_*: one item per interior pixel (border pixels give none): 255 when
//   Gx^2+Gy^2 >= threshold^2, else 0; rsp_tlast on the frame's last one.
// csr_*: image_width at 0x0, image_height at 0x4, edge_threshold at 0x8;
//   out-of-range sizes saturate to 3..MAX_WIDTH / 3..MAX_HEIGHT. Write
//   only while no item is in flight.
// Throughput: one pixel per clock while no stall holds. Each pixel does one
//   read and one write to each line store RAM per cycle, which sets that rate.
// Pipeline: an accepted pixel passes the RAM read, window cells, gradients,
//   squares and the compare/output register, which then holds its result.
// Stall: while the output register holds an item that is not taken, the
//   whole pipeline holds and req_tready is low.
// Reset: position, window and config registers return to defaults; the
//   line stores are not cleared and need a full row written before use.
module prewitt_edge_threshold #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_value
   input  logic [0:0]  req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] edge_value
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   pet_pkg::cfg_type cfg;

   pet_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // effective size minus one
   logic [CW-1:0] wm1;
   logic [RW-1:0] hm1;

   always_comb begin
      if (cfg.image_width < pet_pkg::MIN_DIM) begin
         wm1 = CW'(2);
      end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
         wm1 = CW'(MAX_WIDTH - 1);
      end else begin
         wm1 = CW'(cfg.image_width - 1'b1);
      end
      if (cfg.image_height < pet_pkg::MIN_DIM) begin
         hm1 = RW'(2);
      end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
         hm1 = RW'(MAX_HEIGHT - 1);
      end else begin
         hm1 = RW'(cfg.image_height - 1'b1);
      end
   end

   logic adv, accept;
   logic out_valid_ff;

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   // position of the incoming pixel
   logic [CW-1:0] col_ff, col_in, col_eff;
   logic [RW-1:0] row_ff, row_in, row_eff;
   logic          emit, last;

   always_comb begin
      if (req_tuser[0]) begin
         col_eff = '0;
         row_eff = '0;
      end else begin
         col_eff = (col_ff > wm1) ? wm1 : col_ff;
         row_eff = (row_ff > hm1) ? hm1 : row_ff;
      end
      emit = (col_eff >= CW'(2)) && (row_eff >= RW'(2));
      last = (col_eff == wm1) && (row_eff == hm1);
      if (col_eff == wm1) begin
         col_in = '0;
         row_in = (row_eff == hm1) ? '0 : row_eff + 1'b1;
      end else begin
         col_in = col_eff + 1'b1;
         row_in = row_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line store data back, write the column and feed the cells
   logic              s1_valid_ff, s1_emit_ff, s1_last_ff;
   logic [CW-1:0]     s1_col_ff;
   pet_pkg::pixel_type s1_pix_ff;
   pet_pkg::pixel_type upper_rd, middle_rd, top1, mid1;
   logic              byp_ff, byp_in;
   pet_pkg::pixel_type byp_top_ff, byp_mid_ff;
   logic              s1_write;

   // a read at the address written in the same cycle sees old RAM data
   assign byp_in   = accept && s1_valid_ff && (col_eff == s1_col_ff);
   assign top1     = byp_ff ? byp_top_ff : upper_rd;
   assign mid1     = byp_ff ? byp_mid_ff : middle_rd;
   assign s1_write = s1_valid_ff && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
         byp_ff      <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff  <= col_eff;
         s1_pix_ff  <= req_tdata;
         s1_emit_ff <= emit;
         s1_last_ff <= last;
         byp_top_ff <= mid1;
         byp_mid_ff <= s1_pix_ff;
      end
   end

   pet_ram #(.WIDTH(pet_pkg::PIX_BITS), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_col_ff),
      .wr_data (mid1),
      .rd_en   (accept),
      .rd_addr (col_eff),
      .rd_data (upper_rd)
   );

   pet_ram #(.WIDTH(pet_pkg::PIX_BITS), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (col_eff),
      .rd_data (middle_rd)
   );

   // window: cell 2 takes the newest column, cell 0 holds the oldest
   pet_pkg::column_type                  new_col;
   pet_pkg::column_type                  col2, col1, col0;
   logic [pet_pkg::SUM_BITS-1:0]         sum2, sum1, sum0;
   logic signed [pet_pkg::DIFF_BITS-1:0] dif2, dif1, dif0;

   assign new_col.top = top1;
   assign new_col.mid = mid1;
   assign new_col.bot = s1_pix_ff;

   pet_cell u_cell2 (
      .clock (clock), .reset (reset), .shift (s1_write),
      .col_in (new_col), .col_out (col2), .sum_out (sum2), .diff_out (dif2)
   );

   pet_cell u_cell1 (
      .clock (clock), .reset (reset), .shift (s1_write),
      .col_in (col2), .col_out (col1), .sum_out (sum1), .diff_out (dif1)
   );

   pet_cell u_cell0 (
      .clock (clock), .reset (reset), .shift (s1_write),
      .col_in (col1), .col_out (col0), .sum_out (sum0), .diff_out (dif0)
   );

   // stage 2: window is complete, form the gradients
   logic s2_valid_ff, s2_last_ff;
   logic signed [pet_pkg::GRAD_BITS-1:0] gx, gy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_last_ff <= s1_last_ff;
      end
   end

   always_comb begin
      gx = $signed({1'b0, sum2}) - $signed({1'b0, sum0});
      gy = $signed({{2{dif0[pet_pkg::DIFF_BITS-1]}}, dif0})
         + $signed({{2{dif1[pet_pkg::DIFF_BITS-1]}}, dif1})
         + $signed({{2{dif2[pet_pkg::DIFF_BITS-1]}}, dif2});
   end

   // stage 3: gradients registered, squared
   logic s3_valid_ff, s3_last_ff;
   logic signed [pet_pkg::GRAD_BITS-1:0]   gx_ff, gy_ff;
   logic signed [2*pet_pkg::GRAD_BITS-1:0] prod_x, prod_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_last_ff <= s2_last_ff;
         gx_ff      <= gx;
         gy_ff      <= gy;
      end
   end

   assign prod_x = gx_ff * gx_ff;
   assign prod_y = gy_ff * gy_ff;

   // stage 4: squares registered, add and compare into the output register
   logic s4_valid_ff, s4_last_ff;
   logic [pet_pkg::SQ_BITS-1:0]    sqx_ff, sqy_ff;
   logic [pet_pkg::SQ_BITS:0]      mag2;
   logic [2*pet_pkg::THR_BITS-1:0] thr_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      thr_sq_ff <= (2*pet_pkg::THR_BITS)'(cfg.edge_threshold)
                 * (2*pet_pkg::THR_BITS)'(cfg.edge_threshold);
      if (adv) begin
         s4_last_ff <= s3_last_ff;
         sqx_ff     <= prod_x[pet_pkg::SQ_BITS-1:0];
         sqy_ff     <= prod_y[pet_pkg::SQ_BITS-1:0];
      end
   end

   assign mag2 = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   logic               out_last_ff;
   pet_pkg::pixel_type out_edge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_last_ff <= s4_last_ff;
         out_edge_ff <= (mag2 >= (pet_pkg::SQ_BITS + 1)'(thr_sq_ff)) ?
                        pet_pkg::EDGE_ON : pet_pkg::EDGE_OFF;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_edge_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_bypass_has_item: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> s1_valid_ff)
      else $error("line store bypass set without an item in stage 1");

   a_frame_start_col: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0]) |=> (s1_col_ff == '0))
      else $error("frame start item not placed at column 0");

   a_window_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(s2_valid_ff) |-> $past(s1_valid_ff && s1_emit_ff))
      else $error("gradient stage valid without an interior item");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while output register is blocked");
`endif

endmodule

// ===== sv/pet_ram.sv =====
module pet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pet_cell.sv =====
// One window column: holds three pixels plus their column sum and the
// bottom-minus-top difference, and hands the column to its neighbor.
module pet_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  shift,
   input  pet_pkg::column_type                   col_in,
   output pet_pkg::column_type                   col_out,
   output logic [pet_pkg::SUM_BITS-1:0]          sum_out,
   output logic signed [pet_pkg::DIFF_BITS-1:0]  diff_out
);

   pet_pkg::column_type                  col_ff;
   logic [pet_pkg::SUM_BITS-1:0]         sum_ff, sum_in;
   logic signed [pet_pkg::DIFF_BITS-1:0] diff_ff, diff_in;

   always_comb begin
      sum_in  = pet_pkg::SUM_BITS'(col_in.top) + pet_pkg::SUM_BITS'(col_in.mid)
              + pet_pkg::SUM_BITS'(col_in.bot);
      diff_in = $signed({1'b0, col_in.bot}) - $signed({1'b0, col_in.top});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         sum_ff  <= '0;
         diff_ff <= '0;
      end else if (shift) begin
         col_ff  <= col_in;
         sum_ff  <= sum_in;
         diff_ff <= diff_in;
      end
   end

   assign col_out  = col_ff;
   assign sum_out  = sum_ff;
   assign diff_out = diff_ff;

endmodule

// ===== sv/pet_csr.sv =====
module pet_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output pet_pkg::cfg_type    cfg
);

   pet_pkg::cfg_type cfg_ff;
   logic [1:0]       index;
   logic             wr_en;

   assign index      = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width    <= pet_pkg::WIDTH_RESET;
         cfg_ff.image_height   <= pet_pkg::HEIGHT_RESET;
         cfg_ff.edge_threshold <= pet_pkg::THR_RESET;
      end else if (wr_en) begin
         unique case (index)
            pet_pkg::REG_IMAGE_WIDTH: begin
               cfg_ff.image_width <= csr_pwdata[pet_pkg::WIDTH_BITS-1:0];
            end
            pet_pkg::REG_IMAGE_HEIGHT: begin
               cfg_ff.image_height <= csr_pwdata[pet_pkg::HEIGHT_BITS-1:0];
            end
            pet_pkg::REG_EDGE_THRESHOLD: begin
               cfg_ff.edge_threshold <= csr_pwdata[pet_pkg::THR_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         pet_pkg::REG_IMAGE_WIDTH:    csr_prdata = 32'(cfg_ff.image_width);
         pet_pkg::REG_IMAGE_HEIGHT:   csr_prdata = 32'(cfg_ff.image_height);
         pet_pkg::REG_EDGE_THRESHOLD: csr_prdata = 32'(cfg_ff.edge_threshold);
         default:                     csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== dv/prewitt_edge_threshold_tb.sv =====
`timescale 1ns / 1ps

module prewitt_edge_threshold_tb;

   localparam int MAX_W         = 1024;
   localparam int MAX_H         = 4096;
   localparam int DRAIN_CYCLES  = 10;    // twice the pipeline depth
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_ITEMS  = 500;

   typedef struct packed {
      pet_pkg::pixel_type value;
      logic               last;
   } edge_result_type;

   // Prewitt predictor plus queue of edge results still owed by the block
   class edge_board;
      pet_pkg::pixel_type              line_up[MAX_W];
      pet_pkg::pixel_type              line_mid[MAX_W];
      pet_pkg::pixel_type              win[9];
      int unsigned                     col;
      int unsigned                     row;
      logic [pet_pkg::WIDTH_BITS-1:0]  width_reg;
      logic [pet_pkg::HEIGHT_BITS-1:0] height_reg;
      logic [pet_pkg::THR_BITS-1:0]    thr_reg;
      edge_result_type                 pending_edges[$];
      int                              errors;

      function new();
         for (int i = 0; i < MAX_W; i++) begin
            line_up[i]  = '0;
            line_mid[i] = '0;
         end
         for (int i = 0; i < 9; i++) win[i] = '0;
         col        = 0;
         row        = 0;
         width_reg  = pet_pkg::WIDTH_RESET;
         height_reg = pet_pkg::HEIGHT_RESET;
         thr_reg    = pet_pkg::THR_RESET;
         errors     = 0;
      endfunction

      function int unsigned eff_width();
         if (width_reg < pet_pkg::MIN_DIM) return pet_pkg::MIN_DIM;
         if (width_reg > MAX_W) return MAX_W;
         return 32'(width_reg);
      endfunction

      function int unsigned eff_height();
         if (height_reg < pet_pkg::MIN_DIM) return pet_pkg::MIN_DIM;
         if (height_reg > MAX_H) return MAX_H;
         return 32'(height_reg);
      endfunction

      // returns the value the register now holds
      function logic [31:0] set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            pet_pkg::REG_IMAGE_WIDTH: begin
               width_reg = value[pet_pkg::WIDTH_BITS-1:0];
               return 32'(width_reg);
            end
            pet_pkg::REG_IMAGE_HEIGHT: begin
               height_reg = value[pet_pkg::HEIGHT_BITS-1:0];
               return 32'(height_reg);
            end
            pet_pkg::REG_EDGE_THRESHOLD: begin
               thr_reg = value[pet_pkg::THR_BITS-1:0];
               return 32'(thr_reg);
            end
            default: return '0;
         endcase
      endfunction

      function void take_pixel(pet_pkg::pixel_type pix, logic fs);
         int unsigned        w, h, c, r, i;
         pet_pkg::pixel_type top, mid;
         int                 gx, gy;
         edge_result_type    res;
         w = eff_width();
         h = eff_height();
         if (fs) begin
            col = 0;
            row = 0;
         end
         // position may lie past the edge after a size register shrank
         c = (col >= w) ? w - 1 : col;
         r = (row >= h) ? h - 1 : row;
         top = line_up[c];
         mid = line_mid[c];
         line_up[c]  = mid;
         line_mid[c] = pix;
         for (i = 0; i < 3; i++) begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
         end
         win[2] = top;
         win[5] = mid;
         win[8] = pix;
         if (r >= 2 && c >= 2) begin
            gx = 0;
            gy = 0;
            for (i = 0; i < 3; i++) begin
               gx += int'(win[i*3+2]) - int'(win[i*3]);
               gy += int'(win[6+i]) - int'(win[i]);
            end
            res.value = (gx*gx + gy*gy >= int'(thr_reg) * int'(thr_reg)) ?
                        pet_pkg::EDGE_ON : pet_pkg::EDGE_OFF;
            res.last  = (r == h - 1) && (c == w - 1);
            pending_edges.push_back(res);
         end
         if (c >= w - 1) begin
            col = 0;
            row = (r >= h - 1) ? 0 : r + 1;
         end else begin
            col = c + 1;
            row = r;
         end
      endfunction

      function void check_edge(pet_pkg::pixel_type value, logic last);
         edge_result_type want;
         if (pending_edges.size() == 0) begin
            $display("%0t: unexpected item: edge_value %0d tlast %0b", $time, value, last);
            errors++;
            return;
         end
         want = pending_edges.pop_front();
         if (value !== want.value) begin
            $display("%0t: edge_value mismatch: expected %0d, actual %0d",
                     $time, want.value, value);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: tlast mismatch: expected %0b, actual %0b", $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [7:0] pixel_value
   logic [0:0]  req_tuser   = '0;   // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;          // [7:0] edge_value
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   edge_board   board;
   int unsigned smooth_base = 128;
   int unsigned idle_cycles = 0;
   int unsigned ready_mode  = 0;
   int unsigned mode_left   = 0;
   int unsigned hold_left   = 0;

   prewitt_edge_threshold #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // write, then read back
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] held;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      held = board.set_reg(idx, value);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== held) begin
         $display("%0t: register %0d readback mismatch: expected %0h, actual %0h",
                  $time, idx, held, csr_prdata);
         board.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(input pet_pkg::pixel_type pix, input logic fs);
      req_tvalid   <= 1'b1;
      req_tdata    <= pix;
      req_tuser[0] <= fs;
      do @(posedge clock); while (!req_tready);
      board.take_pixel(pix, fs);
   endtask

   task automatic hold_until_drained(input int unsigned extra);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending_edges.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   // style 1 is a flat area with rare steps, style 2 only black and white
   function automatic pet_pkg::pixel_type next_pixel(int unsigned style);
      case (style)
         0: return pet_pkg::pixel_type'($urandom);
         1: begin
            if ($urandom_range(0, 19) == 0) smooth_base = $urandom_range(0, 240);
            return pet_pkg::pixel_type'(smooth_base + $urandom_range(0, 15));
         end
         default: return $urandom_range(0, 1) ? pet_pkg::EDGE_ON : pet_pkg::EDGE_OFF;
      endcase
   endfunction

   // result side: check, and stall in segments of varying character
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_edge(rsp_tdata, rsp_tlast);
      if (mode_left == 0) begin
         ready_mode <= $urandom_range(0, 2);
         mode_left  <= $urandom_range(40, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 9) < 6);
         default: begin
            if (hold_left != 0) begin
               hold_left <= hold_left - 1;
            end else begin
               rsp_tready <= !rsp_tready;
               hold_left  <= rsp_tready ? $urandom_range(0, 20) : $urandom_range(0, 6);
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("prewitt_edge_threshold_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned n, k, w_before, style, frame_px, burst_left, random_items, phase;
      logic        fs_first, gappy;
      board = new;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // smallest frame, zero threshold: the single interior pixel is an edge
      csr_write(pet_pkg::REG_IMAGE_WIDTH, 32'd2);
      csr_write(pet_pkg::REG_IMAGE_HEIGHT, 32'd0);
      csr_write(pet_pkg::REG_EDGE_THRESHOLD, 32'd0);
      for (k = 0; k < 9; k++) send_pixel(8'd0, k == 0);
      hold_until_drained(DRAIN_CYCLES);
      // full-scale horizontal step against the top threshold, frame wraps on its own
      csr_write(pet_pkg::REG_EDGE_THRESHOLD, 32'd255);
      for (k = 0; k < 9; k++)
         send_pixel((k % 3 == 2) ? 8'd255 : ((k % 3 == 1) ? 8'h5a : 8'd0), 1'b0);
      hold_until_drained(DRAIN_CYCLES);

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         w_before = board.eff_width();
         if (phase == 0 || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 15))
               0: csr_write(pet_pkg::REG_IMAGE_WIDTH, $urandom_range(0, 2));
               1: csr_write(pet_pkg::REG_IMAGE_WIDTH, $urandom_range(1024, 2047));
               default: csr_write(pet_pkg::REG_IMAGE_WIDTH, $urandom_range(3, 12));
            endcase
         end
         if (phase == 0 || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 15))
               0: csr_write(pet_pkg::REG_IMAGE_HEIGHT, $urandom_range(0, 2));
               1: csr_write(pet_pkg::REG_IMAGE_HEIGHT, $urandom_range(4096, 8191));
               default: csr_write(pet_pkg::REG_IMAGE_HEIGHT, $urandom_range(3, 8));
            endcase
         end
         if (phase == 0 || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
               0: csr_write(pet_pkg::REG_EDGE_THRESHOLD, 32'd0);
               1: csr_write(pet_pkg::REG_EDGE_THRESHOLD, 32'd255);
               default: csr_write(pet_pkg::REG_EDGE_THRESHOLD, $urandom_range(0, 255));
            endcase
         end
         frame_px = board.eff_width() * board.eff_height();
         if (frame_px <= 200)
            n = frame_px * $urandom_range(1, 3) + $urandom_range(0, board.eff_width());
         else
            n = $urandom_range(30, 120);
         if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
         // a wider row reaches line store columns this frame has not filled yet
         fs_first = (board.eff_width() > w_before) || ($urandom_range(0, 3) == 0);
         style = $urandom_range(0, 2);
         gappy = ($urandom_range(0, 3) != 0);
         burst_left = 0;
         for (k = 0; k < n; k++) begin
            if (burst_left == 0) begin
               if (gappy) begin
                  req_tvalid <= 1'b0;
                  repeat ($urandom_range(1, 8)) @(posedge clock);
               end
               burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            if (k == n / 2 && (phase == 0 || $urandom_range(0, 7) == 0)) hold_until_drained(0);
            send_pixel(next_pixel(style), (k == 0) ? fs_first : ($urandom_range(0, 149) == 0));
         end
         random_items += n;
         hold_until_drained(DRAIN_CYCLES);
         phase++;
      end

      if (board.errors == 0 && board.pending_edges.size() == 0) begin
         $display("prewitt_edge_threshold_tb: PASS");
      end else begin
         $display("prewitt_edge_threshold_tb: FAIL");
      end
      $finish;
   end

endmodule
